// File: src/block_majority_label_downsample_defines.svh
// Assertion macros shared by the downsampler RTL.
`ifndef BLOCK_MAJORITY_LABEL_DOWNSAMPLE_DEFINES_SVH
`define BLOCK_MAJORITY_LABEL_DOWNSAMPLE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define BMLD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("bmld assertion failed");
// Check that a condition never holds outside reset.
`define BMLD_NEVER(name, clk, rst_n, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bmld forbidden condition seen");
`else
`define BMLD_ASSERT(name, clk, rst_n, prop)
`define BMLD_NEVER(name, clk, rst_n, cond)
`endif
`endif

// File: src/bmld_pkg.sv
// Shared types and constants of the block majority label downsampler.
package bmld_pkg;

    localparam int DEF_MAX_CELLS   = 4096;
    localparam int DEF_NUM_CLASSES = 8;
    localparam int QUEUE_DEPTH     = 4;

    localparam int PIX_W       = 11;
    localparam int LABEL_W     = 16;
    localparam int IDX_W       = 12;
    localparam int CLASS_OUT_W = 3;
    localparam int CNT_W       = 16;
    localparam int DVD_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic
    {
        OP_ACC  = 1'b0,
        OP_READ = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_LR_WIDTH     = 3'd0,
        REG_LR_HEIGHT    = 3'd1,
        REG_SCALE        = 3'd2,
        REG_ORIGIN_X     = 3'd3,
        REG_ORIGIN_Y     = 3'd4,
        REG_LABEL_WIDTH  = 3'd5,
        REG_LABEL_HEIGHT = 3'd6
    } reg_idx_t;

    typedef struct packed
    {
        logic [6:0]  lr_width;
        logic [6:0]  lr_height;
        logic [7:0]  scale;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [11:0] label_width;
        logic [11:0] label_height;
    } cfg_t;

endpackage

// File: src/bmld_if.sv
// Item and result channel interfaces of the downsampler.
interface bmld_item_if import bmld_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [PIX_W-1:0]     pix_x;
    logic [PIX_W-1:0]     pix_y;
    logic [LABEL_W-1:0]   label;
    logic [IDX_W-1:0]     cell_index;

    modport source (output valid, func, pix_x, pix_y, label, cell_index, input ready);
    modport sink   (input valid, func, pix_x, pix_y, label, cell_index, output ready);
endinterface

interface bmld_result_if import bmld_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CLASS_OUT_W-1:0] cell_class;
    logic [IDX_W-1:0]       cell_echo;

    modport source (output valid, cell_class, cell_echo, input ready);
    modport sink   (input valid, cell_class, cell_echo, output ready);
endinterface

// File: src/bmld_front.sv
// Front end: accept words, drop off-grid pixels, divide into cell coordinates.
module bmld_front import bmld_pkg::*; #(
    parameter int  MAX_CELLS   = DEF_MAX_CELLS,
    parameter int  NUM_CLASSES = DEF_NUM_CLASSES,
    localparam int CELL_W      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
    localparam int CLS_W       = $clog2(NUM_CLASSES),
    localparam int CMD_W       = 2 + IDX_W + CLS_W + CELL_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cfg_t             cfg,
    input  logic             clearing,
    bmld_item_if.sink        item,
    output logic             push_valid,
    input  logic             push_ready,
    output logic [CMD_W-1:0] push_data
);

    localparam int              STEP_W     = $clog2(DVD_W);
    localparam logic [16:0]     CELL_LIMIT = 17'(MAX_CELLS);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_CELL,
        ST_PUSH
    } state_t;

    state_t              state_reg, state_next;
    op_t                 op_reg, op_next;
    logic                oob_reg, oob_next;
    logic [IDX_W-1:0]    echo_reg, echo_next;
    logic [CLS_W-1:0]    cls_reg, cls_next;
    logic [CELL_W-1:0]   addr_reg, addr_next;
    logic [DVD_W-1:0]    qx_reg, qx_next, qy_reg, qy_next;
    logic [7:0]          rx_reg, rx_next, ry_reg, ry_next;
    logic [STEP_W-1:0]   cnt_reg, cnt_next;

    logic [16:0]         dx, dy;
    logic                drop;
    logic [8:0]          rx_sh, ry_sh, rx_dif, ry_dif;
    logic                gx, gy;
    logic [13:0]         prod;
    logic [14:0]         cell_sum;
    logic                in_grid, in_store;

    assign item.ready = (state_reg == ST_IDLE) && !clearing;
    assign push_valid = (state_reg == ST_PUSH);
    assign push_data  = {op_reg, oob_reg, echo_reg, cls_reg, addr_reg};

    always_comb
    begin
        dx = {6'b0, item.pix_x} - {cfg.origin_x[15], cfg.origin_x};
        dy = {6'b0, item.pix_y} - {cfg.origin_y[15], cfg.origin_y};
        drop = ({1'b0, item.pix_x} >= cfg.label_width)
            || ({1'b0, item.pix_y} >= cfg.label_height)
            || (cfg.scale == 8'd0)
            || ({1'b0, item.label[3:0]} >= 5'(NUM_CLASSES))
            || dx[16] || dy[16];

        // one restoring divide step on each axis
        rx_sh  = {rx_reg, qx_reg[DVD_W-1]};
        ry_sh  = {ry_reg, qy_reg[DVD_W-1]};
        gx     = rx_sh >= {1'b0, cfg.scale};
        gy     = ry_sh >= {1'b0, cfg.scale};
        rx_dif = rx_sh - {1'b0, cfg.scale};
        ry_dif = ry_sh - {1'b0, cfg.scale};

        in_grid  = (qx_reg < {9'b0, cfg.lr_width}) && (qy_reg < {9'b0, cfg.lr_height});
        prod     = qy_reg[6:0] * cfg.lr_width;
        cell_sum = {1'b0, prod} + {8'b0, qx_reg[6:0]};
        in_store = {2'b0, cell_sum} < CELL_LIMIT;

        state_next = state_reg;
        op_next    = op_reg;
        oob_next   = oob_reg;
        echo_next  = echo_reg;
        cls_next   = cls_reg;
        addr_next  = addr_reg;
        qx_next    = qx_reg;
        qy_next    = qy_reg;
        rx_next    = rx_reg;
        ry_next    = ry_reg;
        cnt_next   = cnt_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid && item.ready)
                begin
                    if (item.func == OP_READ)
                    begin
                        op_next    = OP_READ;
                        echo_next  = item.cell_index;
                        addr_next  = CELL_W'(item.cell_index);
                        oob_next   = {5'b0, item.cell_index} >= CELL_LIMIT;
                        state_next = ST_PUSH;
                    end
                    else if (!drop)
                    begin
                        op_next    = OP_ACC;
                        oob_next   = 1'b0;
                        cls_next   = CLS_W'(item.label[3:0]);
                        qx_next    = dx[DVD_W-1:0];
                        qy_next    = dy[DVD_W-1:0];
                        rx_next    = '0;
                        ry_next    = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                qx_next  = {qx_reg[DVD_W-2:0], gx};
                qy_next  = {qy_reg[DVD_W-2:0], gy};
                rx_next  = gx ? rx_dif[7:0] : rx_sh[7:0];
                ry_next  = gy ? ry_dif[7:0] : ry_sh[7:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DVD_W - 1))
                begin
                    state_next = ST_CELL;
                end
            end
            ST_CELL:
            begin
                addr_next  = CELL_W'(cell_sum);
                state_next = (in_grid && in_store) ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_ACC;
            oob_reg   <= 1'b0;
            echo_reg  <= '0;
            cls_reg   <= '0;
            addr_reg  <= '0;
            qx_reg    <= '0;
            qy_reg    <= '0;
            rx_reg    <= '0;
            ry_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            oob_reg   <= oob_next;
            echo_reg  <= echo_next;
            cls_reg   <= cls_next;
            addr_reg  <= addr_next;
            qx_reg    <= qx_next;
            qy_reg    <= qy_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: src/bmld_queue.sv
// Short command queue between front end and back end.
`include "block_majority_label_downsample_defines.svh"
module bmld_queue import bmld_pkg::*; #(
    parameter int  DATA_W = 8,
    parameter int  DEPTH  = QUEUE_DEPTH,
    localparam int PTR_W  = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `BMLD_ASSERT(a_queue_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH))
    `BMLD_ASSERT(a_queue_grow, clk, rst_n, (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))

endmodule

// File: src/bmld_back.sv
// Back end: counter store, read-modify-write of counts, vote and result register.
`include "block_majority_label_downsample_defines.svh"
module bmld_back import bmld_pkg::*; #(
    parameter int  MAX_CELLS   = DEF_MAX_CELLS,
    parameter int  NUM_CLASSES = DEF_NUM_CLASSES,
    localparam int CELL_W      = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1,
    localparam int CLS_W       = $clog2(NUM_CLASSES),
    localparam int CMD_W       = 2 + IDX_W + CLS_W + CELL_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       scale,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  logic [CMD_W-1:0] pop_data,
    output logic             clearing,
    bmld_result_if.source    result
);

    typedef enum logic [1:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_UPD
    } state_t;

    typedef logic [NUM_CLASSES-1:0][CNT_W-1:0] row_t;

    row_t                mem [MAX_CELLS];
    row_t                rd_data_reg;

    state_t              state_reg, state_next;
    logic [CELL_W-1:0]   clr_cnt_reg, clr_cnt_next;
    op_t                 cmd_op_reg, cmd_op_next;
    logic                cmd_oob_reg, cmd_oob_next;
    logic [IDX_W-1:0]    cmd_echo_reg, cmd_echo_next;
    logic [CLS_W-1:0]    cmd_cls_reg, cmd_cls_next;
    logic [CELL_W-1:0]   cmd_addr_reg, cmd_addr_next;
    logic                out_valid_reg, out_valid_next;
    logic [CLASS_OUT_W-1:0] out_class_reg, out_class_next;
    logic [IDX_W-1:0]    out_echo_reg, out_echo_next;
    logic [13:0]         thr_reg;

    logic                in_op, in_oob;
    logic [IDX_W-1:0]    in_echo;
    logic [CLS_W-1:0]    in_cls;
    logic [CELL_W-1:0]   in_addr;
    logic [15:0]         scale_sq;

    logic                mem_we, mem_re;
    logic [CELL_W-1:0]   mem_waddr, mem_raddr;
    row_t                mem_wdata;
    row_t                row_cur, row_inc;
    logic [CLS_W-1:0]    win;
    logic [CNT_W-1:0]    win_cnt;
    logic                out_free;

    assign {in_op, in_oob, in_echo, in_cls, in_addr} = pop_data;

    assign clearing          = (state_reg == ST_CLEAR);
    assign pop_ready         = (state_reg == ST_IDLE);
    assign result.valid      = out_valid_reg;
    assign result.cell_class = out_class_reg;
    assign result.cell_echo  = out_echo_reg;
    assign scale_sq          = scale * scale;
    assign out_free          = !out_valid_reg || result.ready;

    always_comb
    begin
        row_cur = cmd_oob_reg ? row_t'('0) : rd_data_reg;

        row_inc = row_cur;
        if (row_cur[cmd_cls_reg] != COUNT_MAX)
        begin
            row_inc[cmd_cls_reg] = row_cur[cmd_cls_reg] + 1'b1;
        end

        // class 0 holds until a class from 2 up beats it and the threshold
        win     = '0;
        win_cnt = row_cur[0];
        for (int l = 2; l < NUM_CLASSES; l++)
        begin
            if ((win_cnt < row_cur[l]) && (row_cur[l] > {2'b0, thr_reg}))
            begin
                win     = CLS_W'(l);
                win_cnt = row_cur[l];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cmd_op_next    = cmd_op_reg;
        cmd_oob_next   = cmd_oob_reg;
        cmd_echo_next  = cmd_echo_reg;
        cmd_cls_next   = cmd_cls_reg;
        cmd_addr_next  = cmd_addr_reg;
        out_valid_next = out_valid_reg;
        out_class_next = out_class_reg;
        out_echo_next  = out_echo_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = cmd_addr_reg;
        mem_raddr      = in_addr;
        mem_wdata      = '0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CELL_W'(MAX_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    cmd_op_next   = op_t'(in_op);
                    cmd_oob_next  = in_oob;
                    cmd_echo_next = in_echo;
                    cmd_cls_next  = in_cls;
                    cmd_addr_next = in_addr;
                    mem_re        = !in_oob;
                    state_next    = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (cmd_op_reg == OP_ACC)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = row_inc;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    mem_we         = !cmd_oob_reg;
                    out_valid_next = 1'b1;
                    out_class_next = CLASS_OUT_W'(win);
                    out_echo_next  = cmd_echo_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cmd_op_reg    <= OP_ACC;
            cmd_oob_reg   <= 1'b0;
            cmd_echo_reg  <= '0;
            cmd_cls_reg   <= '0;
            cmd_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_class_reg <= '0;
            out_echo_reg  <= '0;
            thr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            cmd_op_reg    <= cmd_op_next;
            cmd_oob_reg   <= cmd_oob_next;
            cmd_echo_reg  <= cmd_echo_next;
            cmd_cls_reg   <= cmd_cls_next;
            cmd_addr_reg  <= cmd_addr_next;
            out_valid_reg <= out_valid_next;
            out_class_reg <= out_class_next;
            out_echo_reg  <= out_echo_next;
            thr_reg       <= scale_sq[15:2];
        end
    end

    `BMLD_ASSERT(a_result_from_upd, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == ST_UPD))
    `BMLD_ASSERT(a_write_when_owned, clk, rst_n, mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_UPD))
    `BMLD_ASSERT(a_read_waits, clk, rst_n, (state_reg == ST_UPD && cmd_op_reg == OP_READ && !out_free) |=> (state_reg == ST_UPD && $stable(rd_data_reg)))

endmodule

// File: src/block_majority_label_downsample.sv
// Top level of the block majority label downsampler.
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-----------------------------------------
//  item     | in  | valid / ready  | func, pix_x, pix_y, label, cell_index
//  result   | out | valid / ready  | cell_class, cell_echo
//  cfg      | in  | cfg_we         | cfg_index, cfg_data (write only)
//
//  An accumulate word on the grid passes ST_DIV, the 16-step divider, then ST_CELL and ST_PUSH.
//  A pixel dropped at acceptance stays in ST_IDLE; one found off the grid returns from ST_CELL.
//  A read word goes straight to ST_PUSH; the back end passes ST_IDLE and ST_UPD per queued word.
//  After reset a clearing pass zeroes the store, one cell row per cycle, over all
//  MAX_CELLS rows (4096 by default); item.ready stays low until it ends.
//  A stalled result holds in its output register while the front keeps going.
module block_majority_label_downsample import bmld_pkg::*; #(
    parameter int MAX_CELLS   = DEF_MAX_CELLS,
    parameter int NUM_CLASSES = DEF_NUM_CLASSES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bmld_item_if.sink             item,
    bmld_result_if.source         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CELL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CLS_W  = $clog2(NUM_CLASSES);
    localparam int CMD_W  = 2 + IDX_W + CLS_W + CELL_W;

    cfg_t             cfg_reg, cfg_next;
    logic             clearing;
    logic             push_valid, push_ready, pop_valid, pop_ready;
    logic [CMD_W-1:0] push_data, pop_data;

    // Decode configuration writes; ignore indexes past the register list.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LR_WIDTH:     cfg_next.lr_width     = cfg_data[6:0];
                REG_LR_HEIGHT:    cfg_next.lr_height    = cfg_data[6:0];
                REG_SCALE:        cfg_next.scale        = cfg_data[7:0];
                REG_ORIGIN_X:     cfg_next.origin_x     = cfg_data[15:0];
                REG_ORIGIN_Y:     cfg_next.origin_y     = cfg_data[15:0];
                REG_LABEL_WIDTH:  cfg_next.label_width  = cfg_data[11:0];
                REG_LABEL_HEIGHT: cfg_next.label_height = cfg_data[11:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lr_width     <= 7'd1;
            cfg_reg.lr_height    <= 7'd1;
            cfg_reg.scale        <= 8'd1;
            cfg_reg.origin_x     <= 16'd0;
            cfg_reg.origin_y     <= 16'd0;
            cfg_reg.label_width  <= 12'd2048;
            cfg_reg.label_height <= 12'd2048;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: classify words and divide pixel offsets down to a cell number.
    bmld_front #(
        .MAX_CELLS   (MAX_CELLS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .clearing   (clearing),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Decouple the two halves so each can stall on its own.
    bmld_queue #(
        .DATA_W (CMD_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Back: update or vote on one cell row per command, hold the result.
    bmld_back #(
        .MAX_CELLS   (MAX_CELLS),
        .NUM_CLASSES (NUM_CLASSES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .scale     (cfg_reg.scale),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .clearing  (clearing),
        .result    (result)
    );

endmodule

// File: bench/block_majority_label_downsample_tb.sv
// Self-checking bench for the block majority label downsampler: random words, scoreboard.
module block_majority_label_downsample_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bmld_pkg::*;

    localparam int CELLS         = DEF_MAX_CELLS;
    localparam int NCLS          = DEF_NUM_CLASSES;
    // The front end divides each pixel and the back end updates each queued
    // word; this leaves time for both to drain, with a margin on top.
    localparam int SETTLE_CYCLES = 100;
    // The clearing pass after reset keeps the item channel shut while it zeroes
    // all 4096 cells; the quiet-cycle limit sits well above the pass.
    localparam int QUIET_LIMIT   = 20000;
    localparam int PRINT_CAP     = 40;

    typedef enum int
    {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    // One word waiting for the item channel. A word with hold_for_drain set
    // is not offered until every predicted winner has come back.
    typedef struct
    {
        op_t                func;
        logic [PIX_W-1:0]   px;
        logic [PIX_W-1:0]   py;
        logic [LABEL_W-1:0] lbl;
        logic [IDX_W-1:0]   idx;
        bit                 hold_for_drain;
    } pixel_word_t;

    typedef struct
    {
        logic [CLASS_OUT_W-1:0] cls;
        logic [IDX_W-1:0]       echo;
    } winner_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Bench-side copies of everything driven into the block, all known at time zero.
    logic                  drv_valid = 1'b0;
    logic                  drv_func  = 1'b0;
    logic [PIX_W-1:0]      drv_px    = '0;
    logic [PIX_W-1:0]      drv_py    = '0;
    logic [LABEL_W-1:0]    drv_lbl   = '0;
    logic [IDX_W-1:0]      drv_idx   = '0;
    logic                  rsp_ready = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic word_taken = 1'b0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   mismatches    = 0;
    int   quiet_cycles  = 0;

    pixel_word_t words_pending[$];
    winner_t     winners_due[$];

    // Predicted counter store and register file.
    logic [CNT_W-1:0] votes [CELLS][NCLS];
    int unsigned grid_w   = 1;
    int unsigned grid_h   = 1;
    int unsigned win_edge = 1;
    int unsigned map_w    = 2048;
    int unsigned map_h    = 2048;
    int          org_x    = 0;
    int          org_y    = 0;

    bmld_item_if   item_ch();
    bmld_result_if result_ch();

    assign item_ch.valid      = drv_valid;
    assign item_ch.func       = drv_func;
    assign item_ch.pix_x      = drv_px;
    assign item_ch.pix_y      = drv_py;
    assign item_ch.label      = drv_lbl;
    assign item_ch.cell_index = drv_idx;
    assign result_ch.ready    = rsp_ready;

    block_majority_label_downsample i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial forever #5 clk = ~clk;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Count one label pixel into its cell, or drop it when it misses the
    // map, the grid or the counted classes.
    function automatic void tally_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py,
                                        logic [LABEL_W-1:0] lbl);
        int unsigned cls;
        int          dx;
        int          dy;
        int unsigned ci;
        int unsigned cj;
        int unsigned cell_no;
        cls = lbl[3:0];
        if (px >= map_w || py >= map_h) return;
        if (win_edge == 0 || cls >= NCLS) return;
        dx = int'(px) - org_x;
        dy = int'(py) - org_y;
        if (dx < 0 || dy < 0) return;
        ci = int'(dx) / win_edge;
        cj = int'(dy) / win_edge;
        if (ci >= grid_w || cj >= grid_h) return;
        cell_no = cj * grid_w + ci;
        if (cell_no >= CELLS) return;
        // Saturate rather than wrap.
        if (votes[cell_no][cls] != COUNT_MAX)
            votes[cell_no][cls] = votes[cell_no][cls] + 1'b1;
    endfunction

    // Vote one cell and clear its counters. Class 0 leads from the start;
    // class 1 never takes over; a later class must beat the leader strictly
    // and clear a quarter of the window area.
    function automatic logic [CLASS_OUT_W-1:0] cell_winner(logic [IDX_W-1:0] idx);
        int unsigned lead;
        int unsigned thr;
        int unsigned cell_no;
        lead    = 0;
        thr     = (win_edge * win_edge) / 4;
        cell_no = idx;
        if (cell_no >= CELLS) return '0;
        for (int l = 2; l < NCLS; l++)
            if (votes[cell_no][lead] < votes[cell_no][l] && votes[cell_no][l] > thr) lead = l;
        for (int l = 0; l < NCLS; l++) votes[cell_no][l] = '0;
        return lead[CLASS_OUT_W-1:0];
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s, got %0d, want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Sample both channels at the rising edge. Predict on every accepted
    // item word, compare every accepted result word with the oldest winner.
    always @(posedge clk)
    begin
        winner_t want;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            word_taken <= item_ch.valid && item_ch.ready;
            if (item_ch.valid && item_ch.ready)
            begin
                if (op_t'(item_ch.func) == OP_ACC)
                begin
                    tally_pixel(item_ch.pix_x, item_ch.pix_y, item_ch.label);
                end
                else
                begin
                    want.cls  = cell_winner(item_ch.cell_index);
                    want.echo = item_ch.cell_index;
                    winners_due.push_back(want);
                end
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (winners_due.size() == 0)
                begin
                    report_mismatch("result word with no winner due",
                                    int'(result_ch.cell_echo), -1);
                end
                else
                begin
                    want = winners_due.pop_front();
                    if (result_ch.cell_class !== want.cls)
                        report_mismatch($sformatf("cell_class of cell %0d", want.echo),
                                        int'(result_ch.cell_class), int'(want.cls));
                    if (result_ch.cell_echo !== want.echo)
                        report_mismatch("cell_echo", int'(result_ch.cell_echo),
                                        int'(want.echo));
                end
            end
        end
    end

    // Watchdog: end the run when neither channel moves a word for too long.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Driver and receiver, both on the falling edge
    // ---------------------------------------------------------------------

    // Hold the current word until it is taken, then offer the next one
    // unless the sender idles this cycle or the next word waits for a drain.
    always @(negedge clk)
    begin
        pixel_word_t w;
        if (!rst_n)
        begin
            drv_valid <= 1'b0;
        end
        else if (drv_valid && !word_taken)
        begin
            // hold
        end
        else if (words_pending.size() != 0 && $urandom_range(99) >= send_idle_pct
                 && !(words_pending[0].hold_for_drain && winners_due.size() != 0))
        begin
            w = words_pending.pop_front();
            drv_valid <= 1'b1;
            drv_func  <= w.func;
            drv_px    <= w.px;
            drv_py    <= w.py;
            drv_lbl   <= w.lbl;
            drv_idx   <= w.idx;
        end
        else
        begin
            drv_valid <= 1'b0;
        end
    end

    always @(negedge clk) rsp_ready <= ($urandom_range(99) >= stall_pct);

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    function automatic void push_word(op_t f, int x, int y, logic [LABEL_W-1:0] lbl,
                                      int idx, bit hold);
        pixel_word_t w;
        w.func           = f;
        w.px             = x[PIX_W-1:0];
        w.py             = y[PIX_W-1:0];
        w.lbl            = lbl;
        w.idx            = idx[IDX_W-1:0];
        w.hold_for_drain = hold;
        words_pending.push_back(w);
    endfunction

    // Queue a burst that votes a few cells: pixels scattered over their
    // windows, mostly of one leading class per cell, with some stray classes
    // and off-grid noise, then read every cell back. Return the words queued.
    function automatic int vote_burst(bit hold_first_read);
        int unsigned    n_cells;
        int unsigned    span;
        int unsigned    thr;
        int unsigned    total;
        int unsigned    pick;
        int unsigned    cls;
        int unsigned    ci [4];
        int unsigned    cj [4];
        int unsigned    lead [4];
        int             x;
        int             y;
        int             queued;
        logic [LABEL_W-1:0] lbl;
        n_cells = $urandom_range(1, 4);
        span    = (win_edge == 0) ? 1 : win_edge;
        thr     = (win_edge * win_edge) / 4;
        queued  = 0;
        for (int c = 0; c < n_cells; c++)
        begin
            ci[c]   = $urandom_range(grid_w - 1);
            cj[c]   = $urandom_range(grid_h - 1);
            lead[c] = ($urandom_range(4) == 0) ? $urandom_range(15) : $urandom_range(7);
        end
        total = $urandom_range(n_cells, n_cells * (4 + ((thr > 8) ? 8 : thr)));
        for (int p = 0; p < total; p++)
        begin
            pick = $urandom_range(n_cells - 1);
            cls  = ($urandom_range(9) < 7) ? lead[pick] : $urandom_range(15);
            x    = org_x + int'(ci[pick] * span) + int'($urandom_range(span - 1));
            y    = org_y + int'(cj[pick] * span) + int'($urandom_range(span - 1));
            lbl  = LABEL_W'($urandom);
            lbl[3:0] = cls[3:0];
            push_word(OP_ACC, x, y, lbl, int'($urandom_range(4095)), 1'b0);
            queued++;
            if ($urandom_range(9) == 0)
            begin
                push_word(OP_ACC, int'($urandom_range(2047)), int'($urandom_range(2047)),
                          LABEL_W'($urandom), int'($urandom_range(4095)), 1'b0);
                queued++;
            end
        end
        for (int c = 0; c < n_cells; c++)
        begin
            push_word(OP_READ, int'($urandom_range(2047)), int'($urandom_range(2047)),
                      LABEL_W'($urandom), int'(cj[c] * grid_w + ci[c]),
                      hold_first_read && c == 0);
            queued++;
        end
        if ($urandom_range(4) == 0)
        begin
            push_word(OP_READ, 0, 0, '0, int'($urandom_range(4095)), 1'b0);
            queued++;
        end
        return queued;
    endfunction

    // Wait until every word is taken and every winner has come back, then
    // let the pipeline run empty before the next register write.
    task automatic settle();
        do @(posedge clk);
        while (words_pending.size() != 0 || drv_valid || winners_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t r, logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        case (r)
            REG_LR_WIDTH:     grid_w   = v[6:0];
            REG_LR_HEIGHT:    grid_h   = v[6:0];
            REG_SCALE:        win_edge = v[7:0];
            REG_ORIGIN_X:     org_x    = $signed(v);
            REG_ORIGIN_Y:     org_y    = $signed(v);
            REG_LABEL_WIDTH:  map_w    = v[11:0];
            REG_LABEL_HEIGHT: map_h    = v[11:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_grid(int w, int h, int s, int ox, int oy, int lw, int lh);
        write_reg(REG_LR_WIDTH,     CFG_DATA_W'(w));
        write_reg(REG_LR_HEIGHT,    CFG_DATA_W'(h));
        write_reg(REG_SCALE,        CFG_DATA_W'(s));
        write_reg(REG_ORIGIN_X,     CFG_DATA_W'(ox));
        write_reg(REG_ORIGIN_Y,     CFG_DATA_W'(oy));
        write_reg(REG_LABEL_WIDTH,  CFG_DATA_W'(lw));
        write_reg(REG_LABEL_HEIGHT, CFG_DATA_W'(lh));
    endtask

    task automatic set_idle(idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 63; stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 63; end
            default:       begin send_idle_pct = 18; stall_pct = 18; end
        endcase
    endtask

    // Fill the queue with vote bursts until the quota is met, then drain.
    // The first read of the phase waits until all earlier winners are back.
    task automatic run_phase(int quota, idle_mode_t mode);
        int made;
        set_idle(mode);
        made = vote_burst(1'b1);
        while (made < quota) made += vote_burst(1'b0);
        settle();
    endtask

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial
    begin
        for (int c = 0; c < CELLS; c++)
            for (int l = 0; l < NCLS; l++)
                votes[c][l] = '0;
        set_idle(IDLE_NONE);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset settings: one 1x1 cell at the origin,
        // scale 1, so only pixel (0,0) counts and the vote threshold is 0.
        // Leader by count, high label bits ignored.
        push_word(OP_ACC, 0, 0, 16'h0003, 0, 1'b0);
        push_word(OP_ACC, 0, 0, 16'hFFF3, 4095, 1'b0);
        push_word(OP_ACC, 0, 0, 16'h0002, 0, 1'b0);
        push_word(OP_READ, 2047, 2047, 16'hFFFF, 0, 1'b0);
        // Off-grid pixels and uncounted classes leave the cell empty.
        push_word(OP_ACC, 2047, 2047, 16'hFFFF, 0, 1'b0);
        push_word(OP_ACC, 1, 0, 16'h0005, 0, 1'b0);
        push_word(OP_ACC, 0, 0, 16'h000F, 0, 1'b0);
        push_word(OP_ACC, 0, 0, 16'h0008, 0, 1'b0);
        push_word(OP_READ, 0, 0, 16'h0000, 0, 1'b0);
        // Class 1 is counted but never takes the lead.
        push_word(OP_ACC, 0, 0, 16'h0001, 0, 1'b0);
        push_word(OP_READ, 0, 0, 16'h0000, 0, 1'b0);
        // Class 0 holds the lead against a smaller count.
        push_word(OP_ACC, 0, 0, 16'h0000, 0, 1'b0);
        push_word(OP_ACC, 0, 0, 16'h8000, 0, 1'b0);
        push_word(OP_ACC, 0, 0, 16'h7FF7, 0, 1'b0);
        push_word(OP_READ, 0, 0, 16'h0000, 0, 1'b0);
        // A tie keeps the earlier class.
        push_word(OP_ACC, 0, 0, 16'h0004, 0, 1'b0);
        push_word(OP_ACC, 0, 0, 16'h0006, 0, 1'b0);
        push_word(OP_READ, 0, 0, 16'h0000, 0, 1'b0);
        // Highest cell number, never written.
        push_word(OP_READ, 0, 0, 16'h0000, 4095, 1'b1);
        settle();

        // Random phases; every register is rewritten before each one.
        set_grid(4, 3, 2, 10, -5, 2048, 2048);
        run_phase(80, IDLE_SENDER);
        // Grid filling the whole counter store, one pixel per cell.
        set_grid(64, 64, 1, 0, 0, 2048, 2048);
        run_phase(80, IDLE_RECEIVER);
        // Origin at both extremes: nothing lands on the grid.
        set_grid(64, 64, 255, 32767, -32768, 2048, 2048);
        run_phase(20, IDLE_BOTH);
        // Scale zero drops every pixel.
        set_grid(2, 2, 0, 0, 0, 2048, 2048);
        run_phase(30, IDLE_NONE);
        // Empty label map.
        set_grid(3, 3, 1, 0, 0, 0, 7);
        run_phase(30, IDLE_SENDER);
        // Grid hanging over the map corner: edge pixels clipped.
        set_grid(4, 4, 3, 2040, 2040, 2045, 2046);
        run_phase(80, IDLE_RECEIVER);
        // Widest window, threshold out of reach.
        set_grid(1, 1, 255, 0, 0, 2048, 2048);
        run_phase(20, IDLE_BOTH);
        // Grid covering the whole map.
        set_grid(64, 64, 32, 0, 0, 2048, 2048);
        run_phase(40, IDLE_NONE);
        set_grid(16, 16, 1, 100, 200, 1500, 1800);
        run_phase(80, IDLE_BOTH);
        set_grid(5, 7, 4, -3, -9, 2048, 2048);
        run_phase(80, IDLE_RECEIVER);

        settle();
        if (winners_due.size() != 0)
            report_mismatch("winners still due at the end", winners_due.size(), 0);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
